// ----- sv/ple_pkg.sv -----
// Shared types, constants and helper functions for the positional list engine.
`default_nettype none

package ple_pkg;

    // Storage sizing.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    // Derived widths.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed field widths of the channel words.
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int ST_W    = 2;
    localparam int LEN_W   = 7;

    // Width used for position range compares.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Width used to move words between the channel and the store.
    localparam int WIDE_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK           = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POSITION = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL         = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]   length;
    } out_word_t;

    // Requests from the sequencer to the entry allocator.
    typedef struct packed {
        logic             clear;
        logic             pop_chain;
        logic             pop_fresh;
        logic             push;
        logic [IDX_W-1:0] push_idx;
    } alloc_ctl_t;

    // Allocator view seen by the sequencer.
    typedef struct packed {
        logic             chain_nonempty;
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] top;
    } alloc_stat_t;

    // Keep the low DATA_WIDTH bits of a channel value.
    function automatic logic [DATA_WIDTH-1:0] to_entry(input logic [VALUE_W-1:0] v);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(v);
        return t[DATA_WIDTH-1:0];
    endfunction

    // Zero-extend or truncate a stored word onto the channel.
    function automatic logic [VALUE_W-1:0] to_value(input logic [DATA_WIDTH-1:0] w);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(w);
        return t[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: request sequencer, stores and result register.
`default_nettype none

// Channel   Handshake            Word            Direction
// s_        s_valid / s_ready    s_word (op, position, value)        in
// m_        m_valid / m_ready    m_word (status, read_value, length) out
//
// One request is in flight at a time. The link walk follows one entry per
// cycle through the registered read port of the link RAM. An insert at
// position 1 needs no walk; reusing a released entry passes through a wait
// state, so an append at position 64 is the longest request. Clear, undefined
// codes and rejected requests go from decode straight to the result. Reset is
// synchronous and needs no clearing pass. A finished word waits in the output
// register while the next request is accepted; a request can only complete
// once that register is free.

module positional_list_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ple_pkg::in_word_t    s_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ple_pkg::out_word_t        m_word
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_ALLOC      = 4'd2;
    localparam logic [3:0] S_ALLOC_WAIT = 4'd3;
    localparam logic [3:0] S_PLACE      = 4'd4;
    localparam logic [3:0] S_WALK       = 4'd5;
    localparam logic [3:0] S_LINK_WAIT  = 4'd6;
    localparam logic [3:0] S_LINK_WR2   = 4'd7;
    localparam logic [3:0] S_FREE       = 4'd8;
    localparam logic [3:0] S_DATA_WAIT  = 4'd9;
    localparam logic [3:0] S_DONE       = 4'd10;

    logic [3:0] state_reg, state_next;

    // Latched request.
    logic [ple_pkg::OP_W-1:0]       op_reg, op_next;
    logic [ple_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [ple_pkg::DATA_WIDTH-1:0] val_reg, val_next;

    // List state.
    logic [ple_pkg::IDX_W-1:0] first_reg, first_next;
    logic [ple_pkg::CNT_W-1:0] count_reg, count_next;

    // Walk and working registers.
    logic [ple_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic [ple_pkg::IDX_W-1:0] prev_reg, prev_next;
    logic [ple_pkg::IDX_W-1:0] fresh_reg, fresh_next;
    logic [ple_pkg::POS_W-1:0] steps_reg, steps_next;
    logic                      pend_reg, pend_next;

    // Result being built.
    logic [ple_pkg::ST_W-1:0]       st_reg, st_next;
    logic [ple_pkg::DATA_WIDTH-1:0] rd_reg, rd_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    ple_pkg::out_word_t    m_word_reg, m_word_next;

    // RAM ports.
    logic                           link_we, link_re;
    logic [ple_pkg::IDX_W-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
    logic                           ent_we, ent_re;
    logic [ple_pkg::IDX_W-1:0]      ent_waddr, ent_raddr;
    logic [ple_pkg::DATA_WIDTH-1:0] ent_wdata, ent_rdata;

    // Allocator.
    ple_pkg::alloc_ctl_t  actl;
    ple_pkg::alloc_stat_t astat;

    // Range checks.
    logic [ple_pkg::CMP_W-1:0] pos_w, count_w, count_p1;
    logic                      in_list, ins_ok, is_full;
    logic [ple_pkg::IDX_W-1:0] walk_idx;

    assign pos_w    = ple_pkg::CMP_W'(pos_reg);
    assign count_w  = ple_pkg::CMP_W'(count_reg);
    assign count_p1 = count_w + ple_pkg::CMP_W'(1);
    assign in_list  = (pos_reg != '0) && (pos_w <= count_w);
    assign ins_ok   = (pos_reg != '0) && (pos_w <= count_p1);
    assign is_full  = (count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY));

    // During a walk the entry just fetched from the link RAM becomes the
    // current entry without going through a register first.
    assign walk_idx = pend_reg ? link_rdata : cur_reg;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        fresh_next   = fresh_reg;
        steps_next   = steps_reg;
        pend_next    = pend_reg;
        st_next      = st_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;

        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = fresh_reg;
        link_re    = 1'b0;
        link_raddr = walk_idx;
        ent_we     = 1'b0;
        ent_waddr  = walk_idx;
        ent_wdata  = val_reg;
        ent_re     = 1'b0;
        ent_raddr  = walk_idx;

        actl = '0;
        actl.push_idx = cur_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_word.op;
                    pos_next   = s_word.position;
                    val_next   = ple_pkg::to_entry(s_word.value);
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                st_next    = ple_pkg::ST_OK;
                rd_next    = '0;
                cur_next   = first_reg;
                prev_next  = first_reg;
                pend_next  = 1'b0;
                steps_next = pos_reg - ple_pkg::POS_W'(1);
                state_next = S_DONE;
                unique case (op_reg)
                    ple_pkg::OP_READ, ple_pkg::OP_WRITE, ple_pkg::OP_DELETE: begin
                        if (in_list) begin
                            state_next = S_WALK;
                        end else begin
                            st_next = ple_pkg::ST_BAD_POSITION;
                        end
                    end
                    ple_pkg::OP_INSERT: begin
                        priority if (!ins_ok) begin
                            st_next = ple_pkg::ST_BAD_POSITION;
                        end else if (is_full) begin
                            st_next = ple_pkg::ST_FULL;
                        end else begin
                            state_next = S_ALLOC;
                        end
                    end
                    ple_pkg::OP_CLEAR: begin
                        first_next = '0;
                        count_next = '0;
                        actl.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            S_ALLOC: begin
                // Reuse a released entry if there is one, else take a new one.
                ent_we = 1'b1;
                if (astat.chain_nonempty) begin
                    fresh_next = astat.head;
                    ent_waddr  = astat.head;
                    link_re    = 1'b1;
                    link_raddr = astat.head;
                    state_next = S_ALLOC_WAIT;
                end else begin
                    fresh_next     = astat.top;
                    ent_waddr      = astat.top;
                    actl.pop_fresh = 1'b1;
                    state_next     = S_PLACE;
                end
            end

            S_ALLOC_WAIT: begin
                actl.pop_chain = 1'b1;
                state_next     = S_PLACE;
            end

            S_PLACE: begin
                if (pos_reg == ple_pkg::POS_W'(1)) begin
                    link_we    = 1'b1;
                    link_waddr = fresh_reg;
                    link_wdata = first_reg;
                    first_next = fresh_reg;
                    count_next = count_reg + ple_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    cur_next   = first_reg;
                    pend_next  = 1'b0;
                    steps_next = pos_reg - ple_pkg::POS_W'(2);
                    state_next = S_WALK;
                end
            end

            S_WALK: begin
                if (steps_reg == '0) begin
                    cur_next  = walk_idx;
                    pend_next = 1'b0;
                    unique case (op_reg)
                        ple_pkg::OP_READ: begin
                            ent_re     = 1'b1;
                            state_next = S_DATA_WAIT;
                        end
                        ple_pkg::OP_WRITE: begin
                            ent_we     = 1'b1;
                            state_next = S_DONE;
                        end
                        ple_pkg::OP_DELETE: begin
                            // Fetch the word and the successor together.
                            ent_re     = 1'b1;
                            link_re    = 1'b1;
                            state_next = S_LINK_WAIT;
                        end
                        default: begin
                            // Insert: the current entry is the predecessor.
                            link_re    = 1'b1;
                            state_next = S_LINK_WAIT;
                        end
                    endcase
                end else begin
                    link_re    = 1'b1;
                    prev_next  = walk_idx;
                    pend_next  = 1'b1;
                    steps_next = steps_reg - ple_pkg::POS_W'(1);
                end
            end

            S_LINK_WAIT: begin
                if (op_reg == ple_pkg::OP_DELETE) begin
                    rd_next = ent_rdata;
                    if (pos_reg == ple_pkg::POS_W'(1)) begin
                        first_next = link_rdata;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = link_rdata;
                    end
                    state_next = S_FREE;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = fresh_reg;
                    link_wdata = link_rdata;
                    state_next = S_LINK_WR2;
                end
            end

            S_LINK_WR2: begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = fresh_reg;
                count_next = count_reg + ple_pkg::CNT_W'(1);
                state_next = S_DONE;
            end

            S_FREE: begin
                // The removed entry joins the head of the released chain.
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = astat.head;
                actl.push  = 1'b1;
                count_next = count_reg - ple_pkg::CNT_W'(1);
                state_next = S_DONE;
            end

            S_DATA_WAIT: begin
                rd_next    = ent_rdata;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_word_next.status     = st_reg;
                    m_word_next.read_value = ple_pkg::to_value(rd_reg);
                    m_word_next.length     = ple_pkg::LEN_W'(count_reg);
                    state_next             = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            first_reg   <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        fresh_reg  <= fresh_next;
        steps_reg  <= steps_next;
        st_reg     <= st_next;
        rd_reg     <= rd_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // Successor index of every entry.
    ple_ram #(
        .WIDTH (ple_pkg::IDX_W),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (link_re),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    // Data word of every entry.
    ple_ram #(
        .WIDTH (ple_pkg::DATA_WIDTH),
        .DEPTH (ple_pkg::CAPACITY)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_en   (ent_re),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    ple_alloc u_alloc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (actl),
        .pop_next (link_rdata),
        .stat     (astat)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
        else $error("list length exceeds capacity");

    a_idle_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("list length changed without a request in progress");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_word_reg)))
        else $error("result word dropped or changed while waiting");

endmodule

`default_nettype wire

// ----- sv/ple_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ple_alloc.sv -----
// Entry allocator: a high-water mark plus a chain of released entries.
`default_nettype none

module ple_alloc (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ple_pkg::alloc_ctl_t        ctl,
    input  wire logic [ple_pkg::IDX_W-1:0]  pop_next,
    output ple_pkg::alloc_stat_t            stat
);

    // Entries at or above the mark have never been used since the last clear.
    logic [ple_pkg::CNT_W-1:0] hwm_reg, hwm_next;
    // Released entries are chained through their link words.
    logic [ple_pkg::CNT_W-1:0] fcnt_reg, fcnt_next;
    logic [ple_pkg::IDX_W-1:0] head_reg, head_next;

    always_comb begin
        hwm_next  = hwm_reg;
        fcnt_next = fcnt_reg;
        head_next = head_reg;
        priority if (ctl.clear) begin
            hwm_next  = '0;
            fcnt_next = '0;
        end else if (ctl.pop_fresh) begin
            hwm_next = hwm_reg + ple_pkg::CNT_W'(1);
        end else if (ctl.pop_chain) begin
            head_next = pop_next;
            fcnt_next = fcnt_reg - ple_pkg::CNT_W'(1);
        end else if (ctl.push) begin
            head_next = ctl.push_idx;
            fcnt_next = fcnt_reg + ple_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwm_reg  <= '0;
            fcnt_reg <= '0;
        end else begin
            hwm_reg  <= hwm_next;
            fcnt_reg <= fcnt_next;
        end
        head_reg <= head_next;
    end

    assign stat.chain_nonempty = (fcnt_reg != '0);
    assign stat.head           = head_reg;
    assign stat.top            = hwm_reg[ple_pkg::IDX_W-1:0];

    a_pop_chain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop_chain |-> (fcnt_reg != '0))
        else $error("allocator chain popped while empty");

    a_pop_fresh_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop_fresh |-> (hwm_reg < ple_pkg::CNT_W'(ple_pkg::CAPACITY)))
        else $error("allocator mark advanced past capacity");

    a_chain_within_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= hwm_reg)
        else $error("released chain longer than entries ever used");

endmodule

`default_nettype wire
